[sv/hcf_pkg.sv]
package hcf_pkg;

  localparam int MAX_COLS_DEF = 256;
  localparam int MAX_ROWS_DEF = 256;

  localparam int ModeW  = 2;
  localparam int CoordW = 8;
  localparam int PixW   = 8;
  localparam int SizeW  = 9;
  localparam int QualW  = 16;
  localparam int CountW = 17;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;

  localparam int GradW = 11;   // Prewitt sum of 8-bit pixels, signed
  localparam int WtW   = 14;   // Gaussian weight, Q0.16
  localparam int MulW  = 31;   // shared multiplier operand, signed
  localparam int ProdW = 2 * MulW;
  localparam int AccW  = 38;   // weighted product sum
  localparam int RndW  = AccW - 8;
  localparam int StrW  = 30;
  localparam int DivW  = 56;   // dividend bits of det
  localparam int RemW  = 29;   // trace stays below 2**29
  localparam int ThrW  = QualW + StrW;

  localparam logic [ModeW-1:0] MODE_LOAD    = 2'd0;
  localparam logic [ModeW-1:0] MODE_COMPUTE = 2'd1;
  localparam logic [ModeW-1:0] MODE_QUERY   = 2'd2;

  localparam logic [CfgIdxW-1:0] REG_WIDTH   = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_HEIGHT  = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_QUALITY = 2'd2;

  localparam logic KIND_DONE  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam logic [WtW-1:0] W_CENTRE = 14'd13382;
  localparam logic [WtW-1:0] W_EDGE   = 14'd8116;
  localparam logic [WtW-1:0] W_CORNER = 14'd4922;

  localparam logic [QualW-1:0] QUALITY_RST = 16'd655;
  localparam logic [SizeW-1:0] SIZE_RST    = 9'd256;

  // kr and kc run 0..2 for offsets -1..+1
  function automatic logic [WtW-1:0] gauss_weight(logic [1:0] kr, logic [1:0] kc);
    logic mid_r;
    logic mid_c;
    mid_r = (kr == 2'd1);
    mid_c = (kc == 2'd1);
    if (mid_r && mid_c) return W_CENTRE;
    if (mid_r || mid_c) return W_EDGE;
    return W_CORNER;
  endfunction

  function automatic logic [SizeW-1:0] clamp_size(logic [SizeW-1:0] v, int hi);
    if (v < SizeW'(3)) return SizeW'(3);
    if (int'(v) > hi) return SizeW'(hi);
    return v;
  endfunction

endpackage

[sv/hcf_if.sv]
interface hcf_in_if;
  logic                        valid;
  logic                        ready;
  logic [hcf_pkg::ModeW-1:0]   mode;
  logic [hcf_pkg::CoordW-1:0]  col;
  logic [hcf_pkg::CoordW-1:0]  row;
  logic [hcf_pkg::PixW-1:0]    gray;
  modport source (output valid, mode, col, row, gray, input ready);
  modport sink (input valid, mode, col, row, gray, output ready);
endinterface

interface hcf_out_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [hcf_pkg::CoordW-1:0]  col_out;
  logic [hcf_pkg::CoordW-1:0]  row_out;
  logic                        is_corner;
  logic [hcf_pkg::CountW-1:0]  corner_count;
  modport source (output valid, kind, col_out, row_out, is_corner, corner_count,
                  input ready);
  modport sink (input valid, kind, col_out, row_out, is_corner, corner_count,
                output ready);
endinterface

interface hcf_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [hcf_pkg::CfgIdxW-1:0]   index;
  logic [hcf_pkg::CfgDataW-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[sv/harris_corner_frame.sv]
// Load item: one per cycle, no result. Query item: the result is registered from the
// ST_QRY state once the output is free, and the next item is taken after that.
// Compute item: a gradient pass, then smoothing and strength with a bit-serial divider
// over the 56 dividend bits, then a non-max check, all through one shared 31x31
// multiplier and one memory read port per store.
// Reset is synchronous, active low; after reset the corner map is cleared one
// entry per cycle (2**(col bits + row bits) entries, 65536 by default), no item taken.
module harris_corner_frame #(
  parameter int MAX_COLS = hcf_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = hcf_pkg::MAX_ROWS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  hcf_in_if.sink      in_if,
  hcf_out_if.source   out_if,
  hcf_cfg_if.sink     cfg_if
);

  localparam int CW    = $clog2(MAX_COLS);
  localparam int RW    = $clog2(MAX_ROWS);
  localparam int AW    = CW + RW;
  localparam int Depth = 1 << AW;
  localparam int XC    = ((CW > hcf_pkg::SizeW) ? CW : hcf_pkg::SizeW) + 1;
  localparam int XR    = ((RW > hcf_pkg::SizeW) ? RW : hcf_pkg::SizeW) + 1;
  localparam int GW2   = 2 * hcf_pkg::GradW;
  localparam int DcW   = $clog2(hcf_pkg::DivW + 1);

  localparam logic [4:0] ST_CLR   = 5'd0;
  localparam logic [4:0] ST_IDLE  = 5'd1;
  localparam logic [4:0] ST_QRY   = 5'd2;
  localparam logic [4:0] ST_G_RD  = 5'd3;
  localparam logic [4:0] ST_G_AC  = 5'd4;
  localparam logic [4:0] ST_G_WR  = 5'd5;
  localparam logic [4:0] ST_S_RD  = 5'd6;
  localparam logic [4:0] ST_S_M0  = 5'd7;
  localparam logic [4:0] ST_S_M1  = 5'd8;
  localparam logic [4:0] ST_S_M2  = 5'd9;
  localparam logic [4:0] ST_S_M3  = 5'd10;
  localparam logic [4:0] ST_S_M4  = 5'd11;
  localparam logic [4:0] ST_S_M5  = 5'd12;
  localparam logic [4:0] ST_S_M6  = 5'd13;
  localparam logic [4:0] ST_S_RND = 5'd14;
  localparam logic [4:0] ST_S_D0  = 5'd15;
  localparam logic [4:0] ST_S_D1  = 5'd16;
  localparam logic [4:0] ST_S_D2  = 5'd17;
  localparam logic [4:0] ST_S_D3  = 5'd18;
  localparam logic [4:0] ST_S_DIV = 5'd19;
  localparam logic [4:0] ST_S_DQ  = 5'd20;
  localparam logic [4:0] ST_S_WR  = 5'd21;
  localparam logic [4:0] ST_T_MUL = 5'd22;
  localparam logic [4:0] ST_T_LAT = 5'd23;
  localparam logic [4:0] ST_C_RD  = 5'd24;
  localparam logic [4:0] ST_C_AC  = 5'd25;
  localparam logic [4:0] ST_C_WR  = 5'd26;
  localparam logic [4:0] ST_DONE  = 5'd27;

  // memories
  logic [hcf_pkg::PixW-1:0] frm_mem [Depth];
  logic [GW2-1:0]           grad_mem [Depth];
  logic [hcf_pkg::StrW-1:0] str_mem [Depth];
  logic                     cm_mem [Depth];

  logic [hcf_pkg::PixW-1:0] frm_q_r;
  logic [GW2-1:0]           grad_q_r;
  logic [hcf_pkg::StrW-1:0] str_q_r;
  logic                     cm_q_r;

  logic          frm_we, grad_we, str_we, cm_we, cm_wd;
  logic [AW-1:0] frm_wa, cm_wa, cm_ra, nb_addr, pix_addr;

  // control and datapath registers
  logic [4:0]                   state_r, state_nxt;
  logic [AW-1:0]                clr_r, clr_nxt;
  logic [RW-1:0]                r_r, r_nxt;
  logic [CW-1:0]                c_r, c_nxt;
  logic [1:0]                   kr_r, kr_nxt, kc_r, kc_nxt;
  logic signed [hcf_pkg::GradW-1:0] gx_r, gx_nxt, gy_r, gy_nxt;
  logic signed [hcf_pkg::AccW-1:0]  sxx_r, sxx_nxt, syy_r, syy_nxt, sxy_r, sxy_nxt;
  logic signed [hcf_pkg::RndW-1:0]  rx_r, rx_nxt, ry_r, ry_nxt, rxy_r, rxy_nxt;
  logic signed [hcf_pkg::ProdW-1:0] det_r, det_nxt, mul_r;
  logic [hcf_pkg::StrW-1:0]     tr_r, tr_nxt;
  logic [hcf_pkg::RemW-1:0]     rem_r, rem_nxt;
  logic [hcf_pkg::DivW-1:0]     quo_r, quo_nxt;
  logic [DcW-1:0]               dcnt_r, dcnt_nxt;
  logic [hcf_pkg::StrW-1:0]     st_r, st_nxt, max_r, max_nxt;
  logic [hcf_pkg::StrW-1:0]     nb_r, nb_nxt, stc_r, stc_nxt;
  logic [hcf_pkg::ThrW-1:0]     thr_r, thr_nxt;
  logic [hcf_pkg::CountW-1:0]   cnt_r, cnt_nxt;
  logic [hcf_pkg::SizeW-1:0]    w_r, w_nxt, h_r, h_nxt;
  logic [hcf_pkg::QualW-1:0]    q_r, q_nxt;
  logic [hcf_pkg::CoordW-1:0]   qc_r, qc_nxt, qr_r, qr_nxt;
  logic                         qin_r, qin_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic                         out_kind_r, out_kind_nxt;
  logic [hcf_pkg::CoordW-1:0]   out_col_r, out_col_nxt, out_row_r, out_row_nxt;
  logic                         out_corner_r, out_corner_nxt;
  logic [hcf_pkg::CountW-1:0]   out_cnt_r, out_cnt_nxt;

  // helpers
  logic signed [hcf_pkg::MulW-1:0] mul_a, mul_b;
  logic signed [hcf_pkg::GradW-1:0] g_x, g_y;
  logic [hcf_pkg::WtW-1:0] wt;
  logic [RW-1:0] nr;
  logic [CW-1:0] nc;
  logic r_last, c_last, k_last, pix_last, out_free, in_inside, skip_nb, is_c;
  logic [1:0] kr_step, kc_step;
  logic [RW-1:0] r_step;
  logic [CW-1:0] c_step;
  logic signed [hcf_pkg::AccW-1:0] rs_x, rs_y, rs_xy;
  logic signed [hcf_pkg::RndW:0] tr_sum;
  logic [hcf_pkg::RemW+1:0] trial;

  assign in_if.ready  = (state_r == ST_IDLE);
  assign cfg_if.ready = 1'b1;

  assign out_if.valid        = out_valid_r;
  assign out_if.kind         = out_kind_r;
  assign out_if.col_out      = out_col_r;
  assign out_if.row_out      = out_row_r;
  assign out_if.is_corner    = out_corner_r;
  assign out_if.corner_count = out_cnt_r;
  assign out_free = !out_valid_r || out_if.ready;

  assign in_inside = ({1'b0, in_if.col} < w_r) && ({1'b0, in_if.row} < h_r);

  assign r_last   = (XR'(r_r) == XR'(h_r) - XR'(1));
  assign c_last   = (XC'(c_r) == XC'(w_r) - XC'(1));
  assign k_last   = (kr_r == 2'd2) && (kc_r == 2'd2);
  assign pix_last = r_last && c_last;

  assign kc_step = k_last ? 2'd0 : ((kc_r == 2'd2) ? 2'd0 : kc_r + 2'd1);
  assign kr_step = k_last ? 2'd0 : ((kc_r == 2'd2) ? kr_r + 2'd1 : kr_r);
  assign c_step  = c_last ? '0 : c_r + CW'(1);
  assign r_step  = c_last ? (r_last ? '0 : r_r + RW'(1)) : r_r;

  // reflect-101 neighbour position
  always_comb begin
    unique case (kr_r)
      2'd0:    nr = (r_r == '0) ? RW'(1) : r_r - RW'(1);
      2'd2:    nr = r_last ? RW'(h_r - hcf_pkg::SizeW'(2)) : r_r + RW'(1);
      default: nr = r_r;
    endcase
    unique case (kc_r)
      2'd0:    nc = (c_r == '0) ? CW'(1) : c_r - CW'(1);
      2'd2:    nc = c_last ? CW'(w_r - hcf_pkg::SizeW'(2)) : c_r + CW'(1);
      default: nc = c_r;
    endcase
  end

  assign nb_addr  = {nr, nc};
  assign pix_addr = {r_r, c_r};
  assign skip_nb  = ((kr_r == 2'd0) && (r_r == '0)) || ((kr_r == 2'd2) && r_last) ||
                    ((kc_r == 2'd0) && (c_r == '0)) || ((kc_r == 2'd2) && c_last);

  assign g_x = grad_q_r[GW2-1:hcf_pkg::GradW];
  assign g_y = grad_q_r[hcf_pkg::GradW-1:0];
  assign wt  = hcf_pkg::gauss_weight(kr_r, kc_r);

  assign rs_x  = sxx_r + hcf_pkg::AccW'(128);
  assign rs_y  = syy_r + hcf_pkg::AccW'(128);
  assign rs_xy = sxy_r + hcf_pkg::AccW'(128);
  assign tr_sum = {rx_r[hcf_pkg::RndW-1], rx_r} + {ry_r[hcf_pkg::RndW-1], ry_r};
  assign trial  = {1'b0, rem_r, quo_r[hcf_pkg::DivW-1]} - {1'b0, tr_r};
  assign is_c   = ({stc_r, 16'b0} > thr_r) && (stc_r == nb_r);

  assign frm_wa = {RW'(in_if.row), CW'(in_if.col)};
  assign cm_ra  = (state_r == ST_IDLE) ? {RW'(in_if.row), CW'(in_if.col)}
                                       : {RW'(qr_r), CW'(qc_r)};

  always_comb begin
    state_nxt = state_r;  clr_nxt = clr_r;
    r_nxt = r_r;  c_nxt = c_r;  kr_nxt = kr_r;  kc_nxt = kc_r;
    gx_nxt = gx_r;  gy_nxt = gy_r;
    sxx_nxt = sxx_r;  syy_nxt = syy_r;  sxy_nxt = sxy_r;
    rx_nxt = rx_r;  ry_nxt = ry_r;  rxy_nxt = rxy_r;
    det_nxt = det_r;  tr_nxt = tr_r;  rem_nxt = rem_r;  quo_nxt = quo_r;
    dcnt_nxt = dcnt_r;  st_nxt = st_r;  max_nxt = max_r;
    nb_nxt = nb_r;  stc_nxt = stc_r;  thr_nxt = thr_r;  cnt_nxt = cnt_r;
    w_nxt = w_r;  h_nxt = h_r;  q_nxt = q_r;
    qc_nxt = qc_r;  qr_nxt = qr_r;  qin_nxt = qin_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    out_kind_nxt = out_kind_r;  out_col_nxt = out_col_r;  out_row_nxt = out_row_r;
    out_corner_nxt = out_corner_r;  out_cnt_nxt = out_cnt_r;
    mul_a = '0;  mul_b = '0;
    frm_we = 1'b0;  grad_we = 1'b0;  str_we = 1'b0;
    cm_we = 1'b0;  cm_wa = pix_addr;  cm_wd = 1'b0;

    if (cfg_if.valid) begin
      unique case (cfg_if.index)
        hcf_pkg::REG_WIDTH:
          w_nxt = hcf_pkg::clamp_size(cfg_if.data[hcf_pkg::SizeW-1:0], MAX_COLS);
        hcf_pkg::REG_HEIGHT:
          h_nxt = hcf_pkg::clamp_size(cfg_if.data[hcf_pkg::SizeW-1:0], MAX_ROWS);
        hcf_pkg::REG_QUALITY: q_nxt = cfg_if.data;
        default: ;
      endcase
    end

    unique case (state_r)
      ST_CLR: begin
        cm_we = 1'b1;
        cm_wa = clr_r;
        clr_nxt = clr_r + AW'(1);
        if (&clr_r) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_if.valid) begin
          unique case (in_if.mode)
            hcf_pkg::MODE_LOAD: frm_we = in_inside;
            hcf_pkg::MODE_COMPUTE: begin
              r_nxt = '0;  c_nxt = '0;  kr_nxt = '0;  kc_nxt = '0;
              gx_nxt = '0;  gy_nxt = '0;
              sxx_nxt = '0;  syy_nxt = '0;  sxy_nxt = '0;
              cnt_nxt = '0;  max_nxt = '0;
              state_nxt = ST_G_RD;
            end
            hcf_pkg::MODE_QUERY: begin
              qc_nxt = in_if.col;
              qr_nxt = in_if.row;
              qin_nxt = in_inside;
              state_nxt = ST_QRY;
            end
            default: ;
          endcase
        end
      end
      ST_QRY: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt = hcf_pkg::KIND_QUERY;
          out_col_nxt = qc_r;
          out_row_nxt = qr_r;
          out_corner_nxt = qin_r & cm_q_r;
          out_cnt_nxt = cnt_r;
          state_nxt = ST_IDLE;
        end
      end
      ST_G_RD: state_nxt = ST_G_AC;
      ST_G_AC: begin
        if (kc_r == 2'd0) gx_nxt = gx_r - hcf_pkg::GradW'(frm_q_r);
        if (kc_r == 2'd2) gx_nxt = gx_r + hcf_pkg::GradW'(frm_q_r);
        if (kr_r == 2'd0) gy_nxt = gy_r - hcf_pkg::GradW'(frm_q_r);
        if (kr_r == 2'd2) gy_nxt = gy_r + hcf_pkg::GradW'(frm_q_r);
        kr_nxt = kr_step;
        kc_nxt = kc_step;
        state_nxt = k_last ? ST_G_WR : ST_G_RD;
      end
      ST_G_WR: begin
        grad_we = 1'b1;
        gx_nxt = '0;
        gy_nxt = '0;
        r_nxt = r_step;
        c_nxt = c_step;
        state_nxt = pix_last ? ST_S_RD : ST_G_RD;
      end
      ST_S_RD: state_nxt = ST_S_M0;
      ST_S_M0: begin
        mul_a = hcf_pkg::MulW'(g_x);
        mul_b = hcf_pkg::MulW'(g_x);
        state_nxt = ST_S_M1;
      end
      ST_S_M1: begin
        mul_a = mul_r[hcf_pkg::MulW-1:0];
        mul_b = hcf_pkg::MulW'(wt);
        state_nxt = ST_S_M2;
      end
      ST_S_M2: begin
        sxx_nxt = sxx_r + hcf_pkg::AccW'(mul_r);
        mul_a = hcf_pkg::MulW'(g_y);
        mul_b = hcf_pkg::MulW'(g_y);
        state_nxt = ST_S_M3;
      end
      ST_S_M3: begin
        mul_a = mul_r[hcf_pkg::MulW-1:0];
        mul_b = hcf_pkg::MulW'(wt);
        state_nxt = ST_S_M4;
      end
      ST_S_M4: begin
        syy_nxt = syy_r + hcf_pkg::AccW'(mul_r);
        mul_a = hcf_pkg::MulW'(g_x);
        mul_b = hcf_pkg::MulW'(g_y);
        state_nxt = ST_S_M5;
      end
      ST_S_M5: begin
        mul_a = mul_r[hcf_pkg::MulW-1:0];
        mul_b = hcf_pkg::MulW'(wt);
        state_nxt = ST_S_M6;
      end
      ST_S_M6: begin
        sxy_nxt = sxy_r + hcf_pkg::AccW'(mul_r);
        kr_nxt = kr_step;
        kc_nxt = kc_step;
        state_nxt = k_last ? ST_S_RND : ST_S_RD;
      end
      ST_S_RND: begin
        // floor((s + 128) / 256)
        rx_nxt = rs_x[hcf_pkg::AccW-1:8];
        ry_nxt = rs_y[hcf_pkg::AccW-1:8];
        rxy_nxt = rs_xy[hcf_pkg::AccW-1:8];
        state_nxt = ST_S_D0;
      end
      ST_S_D0: begin
        mul_a = hcf_pkg::MulW'(rx_r);
        mul_b = hcf_pkg::MulW'(ry_r);
        state_nxt = ST_S_D1;
      end
      ST_S_D1: begin
        det_nxt = mul_r;
        mul_a = hcf_pkg::MulW'(rxy_r);
        mul_b = hcf_pkg::MulW'(rxy_r);
        state_nxt = ST_S_D2;
      end
      ST_S_D2: begin
        det_nxt = det_r - mul_r;
        state_nxt = ST_S_D3;
      end
      ST_S_D3: begin
        if (!tr_sum[hcf_pkg::RndW] && (tr_sum != '0) &&
            !det_r[hcf_pkg::ProdW-1] && (det_r != '0)) begin
          tr_nxt = tr_sum[hcf_pkg::StrW-1:0];
          rem_nxt = '0;
          quo_nxt = det_r[hcf_pkg::DivW-1:0];
          dcnt_nxt = DcW'(hcf_pkg::DivW);
          state_nxt = ST_S_DIV;
        end else begin
          st_nxt = '0;
          state_nxt = ST_S_WR;
        end
      end
      ST_S_DIV: begin
        if (!trial[hcf_pkg::RemW+1]) begin
          rem_nxt = trial[hcf_pkg::RemW-1:0];
          quo_nxt = {quo_r[hcf_pkg::DivW-2:0], 1'b1};
        end else begin
          rem_nxt = {rem_r[hcf_pkg::RemW-2:0], quo_r[hcf_pkg::DivW-1]};
          quo_nxt = {quo_r[hcf_pkg::DivW-2:0], 1'b0};
        end
        dcnt_nxt = dcnt_r - DcW'(1);
        if (dcnt_r == DcW'(1)) state_nxt = ST_S_DQ;
      end
      ST_S_DQ: begin
        st_nxt = (|quo_r[hcf_pkg::DivW-1:hcf_pkg::StrW]) ? '1 : quo_r[hcf_pkg::StrW-1:0];
        state_nxt = ST_S_WR;
      end
      ST_S_WR: begin
        str_we = 1'b1;
        if (st_r > max_r) max_nxt = st_r;
        sxx_nxt = '0;
        syy_nxt = '0;
        sxy_nxt = '0;
        r_nxt = r_step;
        c_nxt = c_step;
        state_nxt = pix_last ? ST_T_MUL : ST_S_RD;
      end
      ST_T_MUL: begin
        mul_a = hcf_pkg::MulW'(q_r);
        mul_b = hcf_pkg::MulW'(max_r);
        state_nxt = ST_T_LAT;
      end
      ST_T_LAT: begin
        thr_nxt = mul_r[hcf_pkg::ThrW-1:0];
        nb_nxt = '0;
        state_nxt = ST_C_RD;
      end
      ST_C_RD: begin
        // neighbours outside the image take no part in the local maximum
        if (skip_nb) begin
          kr_nxt = kr_step;
          kc_nxt = kc_step;
          state_nxt = k_last ? ST_C_WR : ST_C_RD;
        end else begin
          state_nxt = ST_C_AC;
        end
      end
      ST_C_AC: begin
        if (str_q_r > nb_r) nb_nxt = str_q_r;
        if ((kr_r == 2'd1) && (kc_r == 2'd1)) stc_nxt = str_q_r;
        kr_nxt = kr_step;
        kc_nxt = kc_step;
        state_nxt = k_last ? ST_C_WR : ST_C_RD;
      end
      ST_C_WR: begin
        cm_we = 1'b1;
        cm_wd = is_c;
        cnt_nxt = cnt_r + hcf_pkg::CountW'(is_c);
        nb_nxt = '0;
        r_nxt = r_step;
        c_nxt = c_step;
        state_nxt = pix_last ? ST_DONE : ST_C_RD;
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt = hcf_pkg::KIND_DONE;
          out_col_nxt = '0;
          out_row_nxt = '0;
          out_corner_nxt = 1'b0;
          out_cnt_nxt = cnt_r;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
      clr_r <= '0;
      out_valid_r <= 1'b0;
      cnt_r <= '0;
      w_r <= hcf_pkg::clamp_size(hcf_pkg::SIZE_RST, MAX_COLS);
      h_r <= hcf_pkg::clamp_size(hcf_pkg::SIZE_RST, MAX_ROWS);
      q_r <= hcf_pkg::QUALITY_RST;
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r <= cnt_nxt;
      w_r <= w_nxt;
      h_r <= h_nxt;
      q_r <= q_nxt;
    end
  end

  always_ff @(posedge clk) begin
    r_r <= r_nxt;  c_r <= c_nxt;  kr_r <= kr_nxt;  kc_r <= kc_nxt;
    gx_r <= gx_nxt;  gy_r <= gy_nxt;
    sxx_r <= sxx_nxt;  syy_r <= syy_nxt;  sxy_r <= sxy_nxt;
    rx_r <= rx_nxt;  ry_r <= ry_nxt;  rxy_r <= rxy_nxt;
    det_r <= det_nxt;  tr_r <= tr_nxt;  rem_r <= rem_nxt;  quo_r <= quo_nxt;
    dcnt_r <= dcnt_nxt;  st_r <= st_nxt;  max_r <= max_nxt;
    nb_r <= nb_nxt;  stc_r <= stc_nxt;  thr_r <= thr_nxt;
    qc_r <= qc_nxt;  qr_r <= qr_nxt;  qin_r <= qin_nxt;
    out_kind_r <= out_kind_nxt;  out_col_r <= out_col_nxt;  out_row_r <= out_row_nxt;
    out_corner_r <= out_corner_nxt;  out_cnt_r <= out_cnt_nxt;
    mul_r <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (frm_we) frm_mem[frm_wa] <= in_if.gray;
    frm_q_r <= frm_mem[nb_addr];
  end

  always_ff @(posedge clk) begin
    if (grad_we) grad_mem[pix_addr] <= {gx_r, gy_r};
    grad_q_r <= grad_mem[nb_addr];
  end

  always_ff @(posedge clk) begin
    if (str_we) str_mem[pix_addr] <= st_r;
    str_q_r <= str_mem[nb_addr];
  end

  always_ff @(posedge clk) begin
    if (cm_we) cm_mem[cm_wa] <= cm_wd;
    cm_q_r <= cm_mem[cm_ra];
  end

endmodule

[sim/hcf_tb_if.sv]
`timescale 1ns / 1ps
// Channel interfaces come from the RTL file hcf_if.sv; this file only holds
// the testbench's shared result record.
package hcf_tb_types;

  typedef struct {
    logic                       kind;
    logic [hcf_pkg::CoordW-1:0] col_out;
    logic [hcf_pkg::CoordW-1:0] row_out;
    logic                       is_corner;
    logic [hcf_pkg::CountW-1:0] corner_count;
  } answer_t;
endpackage

[sim/harris_corner_frame_tb.sv]
`timescale 1ns / 1ps
module harris_corner_frame_tb;

  localparam logic [hcf_pkg::ModeW-1:0] MODE_SPARE = 2'd3;
  localparam int GRID = 256;
  localparam int STALL_LIMIT = 400000;
  localparam int ITEM_GOAL = 550;

  logic clk;
  logic rst_n;

  hcf_in_if  in_if();
  hcf_out_if out_if();
  hcf_cfg_if cfg_if();

  harris_corner_frame i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  // golden copy of the block state
  byte unsigned pixels[GRID*GRID];
  int           grad_x[GRID*GRID];
  int           grad_y[GRID*GRID];
  longint       strength[GRID*GRID];
  bit           corner_bits[GRID*GRID];
  longint       peak_strength;
  int           corners_found;
  int           cur_width;
  int           cur_height;
  longint       cur_quality;

  hcf_tb_types::answer_t expected_answers[$];
  int      errors = 0;
  int      items_sent;
  int      send_idle_pct;
  int      recv_stall_pct;
  int      quiet_cycles = 0;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int reflect101(int i, int n);
    if (i < 0) return 1;
    if (i >= n) return n - 2;
    return i;
  endfunction

  function automatic longint round_to_q8(longint s);
    longint t;
    t = s + 128;
    if (t >= 0) return t / 256;
    return -((-t + 255) / 256);
  endfunction

  function automatic longint gauss_tap(int dr, int dc);
    if (dr == 0 && dc == 0) return longint'(hcf_pkg::W_CENTRE);
    if (dr == 0 || dc == 0) return longint'(hcf_pkg::W_EDGE);
    return longint'(hcf_pkg::W_CORNER);
  endfunction

  function automatic int saturate_size(logic [hcf_pkg::CfgDataW-1:0] v);
    int s;
    s = int'(v & 16'h1FF);
    if (s < 3) return 3;
    if (s > GRID) return GRID;
    return s;
  endfunction

  task automatic detect_corners();
    int r, c, dr, dc, k, p, gx, gy;
    longint sxx, syy, sxy, det, tr, wt, q, nb;
    for (r = 0; r < cur_height; r++)
      for (c = 0; c < cur_width; c++) begin
        gx = 0;
        gy = 0;
        for (dr = -1; dr <= 1; dr++)
          for (dc = -1; dc <= 1; dc++) begin
            p = pixels[reflect101(r + dr, cur_height) * GRID + reflect101(c + dc, cur_width)];
            gx += dc * p;
            gy += dr * p;
          end
        grad_x[r*GRID + c] = gx;
        grad_y[r*GRID + c] = gy;
      end
    peak_strength = 0;
    for (r = 0; r < cur_height; r++)
      for (c = 0; c < cur_width; c++) begin
        sxx = 0;
        syy = 0;
        sxy = 0;
        for (dr = -1; dr <= 1; dr++)
          for (dc = -1; dc <= 1; dc++) begin
            k = reflect101(r + dr, cur_height) * GRID + reflect101(c + dc, cur_width);
            wt = gauss_tap(dr, dc);
            sxx += wt * longint'(grad_x[k]) * longint'(grad_x[k]);
            syy += wt * longint'(grad_y[k]) * longint'(grad_y[k]);
            sxy += wt * longint'(grad_x[k]) * longint'(grad_y[k]);
          end
        sxx = round_to_q8(sxx);
        syy = round_to_q8(syy);
        sxy = round_to_q8(sxy);
        det = sxx * syy - sxy * sxy;
        tr = sxx + syy;
        q = 0;
        if (tr > 0 && det > 0) begin
          q = det / tr;
          if (q > 64'h3FFF_FFFF) q = 64'h3FFF_FFFF;
        end
        strength[r*GRID + c] = q;
        if (q > peak_strength) peak_strength = q;
      end
    corners_found = 0;
    for (r = 0; r < cur_height; r++)
      for (c = 0; c < cur_width; c++) begin
        nb = 0;
        for (dr = -1; dr <= 1; dr++)
          for (dc = -1; dc <= 1; dc++)
            if (r + dr >= 0 && r + dr < cur_height && c + dc >= 0 && c + dc < cur_width &&
                strength[(r+dr)*GRID + c + dc] > nb)
              nb = strength[(r+dr)*GRID + c + dc];
        k = r*GRID + c;
        corner_bits[k] = ((strength[k] << 16) > cur_quality * peak_strength) &&
                         (strength[k] == nb);
        corners_found += corner_bits[k];
      end
    corners_found &= 32'h1FFFF;
  endtask

  task automatic apply_item(logic [hcf_pkg::ModeW-1:0] mode, int col, int row, int gray);
    hcf_tb_types::answer_t a;
    bit in_frame;
    in_frame = col < cur_width && row < cur_height;
    case (mode)
      hcf_pkg::MODE_LOAD: if (in_frame) pixels[row*GRID + col] = byte'(gray);
      hcf_pkg::MODE_COMPUTE: begin
        detect_corners();
        a.kind = hcf_pkg::KIND_DONE;
        a.col_out = '0;
        a.row_out = '0;
        a.is_corner = 1'b0;
        a.corner_count = hcf_pkg::CountW'(corners_found);
        expected_answers.insert(expected_answers.size(), a);
      end
      hcf_pkg::MODE_QUERY: begin
        a.kind = hcf_pkg::KIND_QUERY;
        a.col_out = hcf_pkg::CoordW'(col);
        a.row_out = hcf_pkg::CoordW'(row);
        a.is_corner = in_frame ? corner_bits[row*GRID + col] : 1'b0;
        a.corner_count = hcf_pkg::CountW'(corners_found);
        expected_answers.insert(expected_answers.size(), a);
      end
      default: ;
    endcase
  endtask

  // valid stays high between back-to-back items; it drops only to idle
  task automatic send_item(logic [hcf_pkg::ModeW-1:0] mode, int col, int row, int gray);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.mode  <= mode;
    in_if.col   <= hcf_pkg::CoordW'(col);
    in_if.row   <= hcf_pkg::CoordW'(row);
    in_if.gray  <= hcf_pkg::PixW'(gray);
    do @(posedge clk); while (!in_if.ready);
    apply_item(mode, col, row, gray);
    items_sent++;
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (expected_answers.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [hcf_pkg::CfgIdxW-1:0] idx,
                           logic [hcf_pkg::CfgDataW-1:0] data);
    drain_results();
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      hcf_pkg::REG_WIDTH:   cur_width = saturate_size(data);
      hcf_pkg::REG_HEIGHT:  cur_height = saturate_size(data);
      hcf_pkg::REG_QUALITY: cur_quality = longint'(data);
      default: ;
    endcase
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  // style: 0 noise, 1 flat, 2 bright box, 3 black/white speckle
  task automatic load_frame(int style);
    int r, c, g, flat, r0, c0;
    flat = $urandom_range(255);
    r0 = $urandom_range(cur_height - 1);
    c0 = $urandom_range(cur_width - 1);
    for (r = 0; r < cur_height; r++)
      for (c = 0; c < cur_width; c++) begin
        case (style)
          0: g = $urandom_range(255);
          1: g = flat;
          2: g = (r >= r0 && c >= c0 && r < r0 + 3 && c < c0 + 3) ? 255 : 10;
          default: g = $urandom_range(1) ? 255 : 0;
        endcase
        send_item(hcf_pkg::MODE_LOAD, c, r, g);
        if ($urandom_range(7) == 0) begin
          if ($urandom_range(1) && cur_width < GRID)
            send_item(hcf_pkg::MODE_LOAD, $urandom_range(GRID - 1, cur_width),
                      $urandom_range(255), $urandom_range(255));
          else
            send_item(MODE_SPARE, $urandom_range(255), $urandom_range(255),
                      $urandom_range(255));
        end
      end
  endtask

  task automatic test_directed_frame();
    int r, c;
    send_item(hcf_pkg::MODE_QUERY, 0, 0, 0);
    send_item(hcf_pkg::MODE_QUERY, 255, 255, 255);
    send_item(hcf_pkg::MODE_LOAD, 255, 255, 255);
    send_item(MODE_SPARE, 255, 255, 255);
    write_reg(hcf_pkg::REG_WIDTH, 16'd0);
    write_reg(hcf_pkg::REG_HEIGHT, 16'd2);
    write_reg(hcf_pkg::REG_QUALITY, 16'hFFFF);
    for (r = 0; r < 3; r++)
      for (c = 0; c < 3; c++)
        send_item(hcf_pkg::MODE_LOAD, c, r, ((r + c) % 2) ? 255 : 0);
    send_item(hcf_pkg::MODE_COMPUTE, 0, 0, 0);
    for (r = 0; r < 3; r++)
      for (c = 0; c < 3; c++)
        send_item(hcf_pkg::MODE_QUERY, c, r, 0);
    send_item(hcf_pkg::MODE_QUERY, 3, 0, 0);
    send_item(hcf_pkg::MODE_QUERY, 0, 3, 0);
    // zero trace everywhere: flat frame, no corner at any quality
    write_reg(hcf_pkg::REG_QUALITY, 16'd0);
    load_frame(1);
    send_item(hcf_pkg::MODE_COMPUTE, 0, 0, 0);
    send_item(hcf_pkg::MODE_QUERY, 1, 1, 0);
    drain_results();
  endtask

  task automatic test_size_saturation();
    write_reg(hcf_pkg::REG_WIDTH, 16'd511);
    write_reg(hcf_pkg::REG_HEIGHT, 16'd300);
    send_item(hcf_pkg::MODE_QUERY, 255, 255, 0);
    send_item(hcf_pkg::MODE_QUERY, 200, 100, 0);
    write_reg(hcf_pkg::REG_WIDTH, 16'hFFFF);
    write_reg(hcf_pkg::REG_HEIGHT, 16'd256);
    send_item(hcf_pkg::MODE_QUERY, 1, 2, 0);
    write_reg(hcf_pkg::REG_WIDTH, 16'd1);
    write_reg(hcf_pkg::REG_HEIGHT, 16'd0);
    send_item(hcf_pkg::MODE_QUERY, 3, 3, 0);
    send_item(hcf_pkg::MODE_QUERY, 2, 2, 0);
    drain_results();
  endtask

  task automatic test_random_frames();
    int frame_no, n, pick;
    frame_no = 0;
    while (items_sent < ITEM_GOAL) begin
      case (frame_no % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
        default: begin send_idle_pct = 30; recv_stall_pct = 30; end
      endcase
      if (frame_no % 7 == 6) begin
        write_reg(hcf_pkg::REG_WIDTH, 16'd16);
        write_reg(hcf_pkg::REG_HEIGHT, 16'd12);
      end else begin
        write_reg(hcf_pkg::REG_WIDTH, 16'($urandom_range(9, 3)));
        write_reg(hcf_pkg::REG_HEIGHT, 16'($urandom_range(9, 3)));
      end
      pick = $urandom_range(3);
      write_reg(hcf_pkg::REG_QUALITY, pick == 0 ? 16'd0 : pick == 1 ? 16'hFFFF :
                pick == 2 ? hcf_pkg::QUALITY_RST : 16'($urandom_range(16'hFFFF)));
      load_frame(frame_no % 5 == 4 ? 1 : $urandom_range(3) == 0 ? 3 :
                 $urandom_range(1) ? 2 : 0);
      // hold off the compute until the pipe is empty on odd frames
      if (frame_no % 2) drain_results();
      send_item(hcf_pkg::MODE_COMPUTE, $urandom_range(255), $urandom_range(255),
                $urandom_range(255));
      for (n = 0; n < 18; n++) begin
        if ($urandom_range(4) == 0)
          send_item(hcf_pkg::MODE_QUERY, $urandom_range(255), $urandom_range(255),
                    $urandom_range(255));
        else if ($urandom_range(5) == 0)
          send_item(hcf_pkg::MODE_LOAD, $urandom_range(cur_width - 1),
                    $urandom_range(cur_height - 1), $urandom_range(255));
        else
          send_item(hcf_pkg::MODE_QUERY, $urandom_range(cur_width - 1),
                    $urandom_range(cur_height - 1), $urandom_range(255));
      end
      frame_no++;
    end
    drain_results();
  endtask

  always @(posedge clk) begin
    out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin : check_answers
    hcf_tb_types::answer_t e;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_answers.size() == 0) begin
        $error("unexpected result item, kind %0d", out_if.kind);
        errors++;
      end else begin
        e = expected_answers.pop_front();
        if (out_if.kind !== e.kind) begin
          $error("kind: expected %0d actual %0d", e.kind, out_if.kind);
          errors++;
        end
        if (out_if.col_out !== e.col_out) begin
          $error("col_out: expected %0d actual %0d", e.col_out, out_if.col_out);
          errors++;
        end
        if (out_if.row_out !== e.row_out) begin
          $error("row_out: expected %0d actual %0d", e.row_out, out_if.row_out);
          errors++;
        end
        if (out_if.is_corner !== e.is_corner) begin
          $error("is_corner: expected %0d actual %0d", e.is_corner, out_if.is_corner);
          errors++;
        end
        if (out_if.corner_count !== e.corner_count) begin
          $error("corner_count: expected %0d actual %0d", e.corner_count,
                 out_if.corner_count);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    items_sent = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    cur_width = GRID;
    cur_height = GRID;
    cur_quality = longint'(hcf_pkg::QUALITY_RST);
    peak_strength = 0;
    corners_found = 0;
    foreach (corner_bits[i]) corner_bits[i] = 1'b0;
    rst_n <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.mode <= hcf_pkg::MODE_LOAD;
    in_if.col <= '0;
    in_if.row <= '0;
    in_if.gray <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= hcf_pkg::REG_WIDTH;
    cfg_if.data <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_frame();
    test_size_saturation();
    test_random_frames();
    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

[filelist.f]
sv/hcf_pkg.sv
sv/hcf_if.sv
sv/harris_corner_frame.sv
sim/hcf_tb_if.sv
sim/harris_corner_frame_tb.sv
